// File: design/dts_pkg.sv
// Shared types and constants for the disk transfer segmenter.
package dts_pkg;

	// Result status codes; the job kind in the queue uses the same codes.
	localparam logic [1:0] ST_SEG     = 2'd0;
	localparam logic [1:0] ST_BAD     = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;
	localparam logic [1:0] ST_RECORD  = 2'd3;

	// Configuration register indexes.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_PRESENT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LARGE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXT     = 2'd2;

	// Drive geometry.
	localparam logic [13:0] TRACK_BYTES  = 14'd10240;
	localparam logic [15:0] SMALL_BLOCKS = 16'd10240;
	localparam logic [15:0] LARGE_BLOCKS = 16'd20480;

	// Controller function codes.
	localparam logic [5:0] CMD_READ  = 6'o14;
	localparam logic [5:0] CMD_WRITE = 6'o12;

	// Reciprocal of five scaled by 2^18, used for block / 20.
	localparam logic [15:0] DIV5_RECIP = 16'd52429;

	// At most this many segments per request.
	localparam int MAX_SEGMENTS = 8;
	localparam int SEG_CNT_W    = 3;

	// Depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// One classified item on its way to the back end.
	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  drive;
		logic        is_read;
		logic [9:0]  track;
		logic [5:0]  sector;
		logic [17:0] addr;
		logic [15:0] left;
	} dts_job_t;

endpackage

// File: design/dts_in_if.sv
// Request channel: transfer requests and header position reports.
interface dts_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [1:0]  drive;
	logic        is_read;
	logic [15:0] block_number;
	logic [15:0] byte_count;
	logic [15:0] memory_address;
	logic [15:0] header_word;

	modport source (
		output valid, action, drive, is_read, block_number, byte_count,
			memory_address, header_word,
		input  ready
	);
	modport sink (
		input  valid, action, drive, is_read, block_number, byte_count,
			memory_address, header_word,
		output ready
	);
endinterface

// File: design/dts_out_if.sv
// Result channel: controller register words for one segment or a status.
interface dts_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] seek_word;
	logic [15:0] disk_address_word;
	logic [17:0] bus_address;
	logic [15:0] word_count_word;
	logic [15:0] command_word;
	logic        last;

	modport source (
		output valid, status, seek_word, disk_address_word, bus_address,
			word_count_word, command_word, last,
		input  ready
	);
	modport sink (
		input  valid, status, seek_word, disk_address_word, bus_address,
			word_count_word, command_word, last,
		output ready
	);
endinterface

// File: design/dts_cfg_if.sv
// Configuration write channel.
interface dts_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [dts_pkg::CFG_IDX_W-1:0]  index;
	logic [dts_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: design/dts_front.sv
// Front end: configuration registers, known-position flags and item classification.
module dts_front #(
	parameter int DRIVES = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	dts_in_if.sink            req,
	dts_cfg_if.sink           cfg,
	output logic              job_valid,
	input  logic              job_ready,
	output dts_pkg::dts_job_t job
);

	logic [3:0]        present_q;
	logic [3:0]        large_q;
	logic [1:0]        ext_q;
	logic [DRIVES-1:0] known_q;

	logic        accept;
	logic        drive_ok;
	logic        known;
	logic [15:0] nblocks;
	logic [29:0] quot_prod;
	logic [11:0] quot;
	logic [15:0] rem_full;

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			large_q   <= '0;
			ext_q     <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				dts_pkg::REG_PRESENT: present_q <= cfg.data;
				dts_pkg::REG_LARGE:   large_q   <= cfg.data;
				dts_pkg::REG_EXT:     ext_q     <= cfg.data[1:0];
				default: ;
			endcase
		end
	end

	// Items pass straight into the queue when it has room.
	assign req.ready = job_ready;
	assign job_valid = req.valid;
	assign accept    = req.valid && job_ready;

	// Known flag of the addressed drive.
	always_comb begin
		known = 1'b0;
		for (int d = 0; d < DRIVES; d++) begin
			if (req.drive == 2'(d)) begin
				known = known_q[d];
			end
		end
	end

	// A header report marks its drive's position as known.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_q <= '0;
		end else if (accept && req.action) begin
			for (int d = 0; d < DRIVES; d++) begin
				if (req.drive == 2'(d)) begin
					known_q[d] <= 1'b1;
				end
			end
		end
	end

	// Block / 20 as (block / 4) / 5 through a reciprocal multiply.
	assign quot_prod = 30'(req.block_number[15:2]) * 30'(dts_pkg::DIV5_RECIP);
	assign quot      = quot_prod[29:18];
	assign rem_full  = req.block_number - ({4'b0, quot} << 4) - ({4'b0, quot} << 2);

	assign drive_ok = (32'(req.drive) < DRIVES) && present_q[req.drive];
	assign nblocks  = large_q[req.drive] ? dts_pkg::LARGE_BLOCKS : dts_pkg::SMALL_BLOCKS;

	// Classify the item and prepare the fields that the back end walks through.
	always_comb begin
		job.drive   = req.drive;
		job.is_read = req.is_read;
		job.sector  = {rem_full[4:0], 1'b0};
		job.addr    = {ext_q, req.memory_address};
		job.left    = req.byte_count;
		job.track   = quot[9:0];
		if (req.action) begin
			job.kind  = dts_pkg::ST_RECORD;
			job.track = req.header_word[15:6];
		end else if (!drive_ok) begin
			job.kind = dts_pkg::ST_BAD;
		end else if (!known) begin
			job.kind = dts_pkg::ST_UNKNOWN;
		end else if (req.block_number >= nblocks) begin
			job.kind = dts_pkg::ST_BAD;
		end else begin
			job.kind = dts_pkg::ST_SEG;
		end
	end

endmodule

// File: design/dts_queue.sv
// Short queue of classified items between the front and back ends.
module dts_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  dts_pkg::dts_job_t push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output dts_pkg::dts_job_t pop_data
);

	localparam int PTR_W = $clog2(dts_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(dts_pkg::QUEUE_DEPTH + 1);

	dts_pkg::dts_job_t entries_q [dts_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != CNT_W'(dts_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(dts_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(dts_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(dts_pkg::QUEUE_DEPTH))
		else $error("queue fill count beyond depth");

	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue fill count did not grow on a push");

endmodule

// File: design/dts_back.sv
// Back end: walks one job through its track segments and drives the result register.
module dts_back #(
	parameter int DRIVES = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  dts_pkg::dts_job_t job,
	dts_out_if.source         rsp
);

	logic [9:0] head_track_q [DRIVES];

	logic                           busy_q;
	logic [dts_pkg::SEG_CNT_W-1:0]  k_q;
	logic [1:0]                     kind_q;
	logic [1:0]                     drive_q;
	logic                           is_read_q;
	logic [9:0]                     track_q;
	logic [5:0]                     sector_q;
	logic [17:0]                    addr_q;
	logic [15:0]                    left_q;

	logic        rsp_valid_q;
	logic [1:0]  rsp_status_q;
	logic [15:0] rsp_seek_q;
	logic [15:0] rsp_da_q;
	logic [17:0] rsp_ba_q;
	logic [15:0] rsp_wc_q;
	logic [15:0] rsp_cmd_q;
	logic        rsp_last_q;

	logic        pop;
	logic        produce;
	logic        is_seg;
	logic [9:0]  cur_track;
	logic [8:0]  cur_cyl;
	logic [8:0]  dst_cyl;
	logic        outward;
	logic [8:0]  seek_mag;
	logic [15:0] seek;
	logic [13:0] part_full;
	logic [15:0] part;
	logic [15:0] left_next;
	logic [15:0] word_count;
	logic [5:0]  opcode;
	logic [15:0] command;
	logic        seg_fin;

	assign job_ready = !busy_q;
	assign pop       = job_valid && !busy_q;
	assign produce   = busy_q && (!rsp_valid_q || rsp.ready);
	assign is_seg    = kind_q == dts_pkg::ST_SEG;

	// Head track of the job's drive.
	always_comb begin
		cur_track = '0;
		for (int d = 0; d < DRIVES; d++) begin
			if (drive_q == 2'(d)) begin
				cur_track = head_track_q[d];
			end
		end
	end

	// Relative seek between cylinders, with direction and head select.
	assign cur_cyl  = cur_track[9:1];
	assign dst_cyl  = track_q[9:1];
	assign outward  = cur_cyl < dst_cyl;
	assign seek_mag = outward ? dst_cyl - cur_cyl : cur_cyl - dst_cyl;
	assign seek     = {seek_mag, 7'b0} | (outward ? 16'd5 : 16'd1) |
		{11'b0, track_q[0], 4'b0};

	// Segment length is the rest of the track or what is left, whichever is less.
	assign part_full  = dts_pkg::TRACK_BYTES - {sector_q, 8'b0};
	assign part       = (left_q < {2'b0, part_full}) ? left_q : {2'b0, part_full};
	assign left_next  = left_q - part;
	assign word_count = 16'd0 - {1'b0, part[15:1]};
	assign seg_fin    = (left_next == '0) ||
		(k_q == dts_pkg::SEG_CNT_W'(dts_pkg::MAX_SEGMENTS - 1));

	assign opcode  = is_read_q ? dts_pkg::CMD_READ : dts_pkg::CMD_WRITE;
	assign command = {6'b0, drive_q, 8'b0} | {10'b0, addr_q[17:16], 4'b0} |
		{10'b0, opcode};

	// Job sequencing and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			k_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (produce) begin
				if (!is_seg || seg_fin) begin
					busy_q <= 1'b0;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
			if (produce) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Job fields advance by one track per segment.
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q    <= job.kind;
			drive_q   <= job.drive;
			is_read_q <= job.is_read;
			track_q   <= job.track;
			sector_q  <= job.sector;
			addr_q    <= job.addr;
			left_q    <= job.left;
		end else if (produce && is_seg && !seg_fin) begin
			track_q  <= track_q + 1'b1;
			sector_q <= '0;
			addr_q   <= addr_q + {2'b0, part};
			left_q   <= left_next;
		end
	end

	// Head position follows every segment and every header report.
	always_ff @(posedge clk) begin
		if (produce && (is_seg || kind_q == dts_pkg::ST_RECORD)) begin
			for (int d = 0; d < DRIVES; d++) begin
				if (drive_q == 2'(d)) begin
					head_track_q[d] <= track_q;
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (produce) begin
			rsp_status_q <= kind_q;
			if (is_seg) begin
				rsp_seek_q <= seek;
				rsp_da_q   <= {track_q, sector_q};
				rsp_ba_q   <= addr_q;
				rsp_wc_q   <= word_count;
				rsp_cmd_q  <= command;
				rsp_last_q <= seg_fin;
			end else begin
				rsp_seek_q <= '0;
				rsp_da_q   <= '0;
				rsp_ba_q   <= '0;
				rsp_wc_q   <= '0;
				rsp_cmd_q  <= '0;
				rsp_last_q <= 1'b1;
			end
		end
	end

	assign rsp.valid             = rsp_valid_q;
	assign rsp.status            = rsp_status_q;
	assign rsp.seek_word         = rsp_seek_q;
	assign rsp.disk_address_word = rsp_da_q;
	assign rsp.bus_address       = rsp_ba_q;
	assign rsp.word_count_word   = rsp_wc_q;
	assign rsp.command_word      = rsp_cmd_q;
	assign rsp.last              = rsp_last_q;

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_status_q != dts_pkg::ST_SEG |-> rsp_last_q)
		else $error("status result without last");

	a_segment_cap: assert property (@(posedge clk) disable iff (!arst_n)
		produce && is_seg &&
		k_q == dts_pkg::SEG_CNT_W'(dts_pkg::MAX_SEGMENTS - 1) |-> seg_fin)
		else $error("request ran past the segment limit");

	a_segment_moves: assert property (@(posedge clk) disable iff (!arst_n)
		produce && is_seg && !seg_fin |-> part != '0)
		else $error("intermediate segment moved no bytes");

	a_busy_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> busy_q && !job_ready)
		else $error("job taken but back end not busy");

endmodule

// File: design/disk_transfer_segmenter_unit.sv
// Disk transfer segmenter top level. A transfer request for one of up to four
// cartridge drives becomes one result per track segment (at most eight), each
// carrying the seek, disk address, bus address, word count and command words;
// a header report records the drive's track and gives one status result, and
// a bad drive, bad block or unknown position gives one error result. The front
// end takes one item per cycle while its two-entry queue has room. The back end
// takes a job from the queue only while idle and then produces its results one
// after another, holding whenever the result register has not been taken; it
// takes no new job until the last result of the current one has been produced.
module disk_transfer_segmenter_unit #(
	parameter int DRIVES = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	dts_in_if.sink   req,
	dts_out_if.source rsp,
	dts_cfg_if.sink  cfg
);

	dts_pkg::dts_job_t front_job;
	dts_pkg::dts_job_t back_job;
	logic              front_valid;
	logic              front_ready;
	logic              back_valid;
	logic              back_ready;

	// Classification and configuration.
	dts_front #(
		.DRIVES (DRIVES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg       (cfg),
		.job_valid (front_valid),
		.job_ready (front_ready),
		.job       (front_job)
	);

	// Decoupling queue.
	dts_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_job),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (back_job)
	);

	// Segment generation.
	dts_back #(
		.DRIVES (DRIVES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (back_valid),
		.job_ready (back_ready),
		.job       (back_job),
		.rsp       (rsp)
	);

endmodule

// File: tb/disk_transfer_segmenter_unit_tb.sv
// Self-checking testbench for the disk transfer segmenter with directed, stall and random tests.
module disk_transfer_segmenter_unit_tb;

	localparam int NUM_DRIVES    = 4;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int MAX_GAP       = 13;
	localparam int SETTLE_CYCLES = 20;
	localparam int REPORT_LIMIT  = 10;
	localparam int LONG_HOLD     = 300;

	// One request or header report as offered on the request channel.
	typedef struct {
		logic        action;
		logic [1:0]  drive;
		logic        is_read;
		logic [15:0] block_number;
		logic [15:0] byte_count;
		logic [15:0] memory_address;
		logic [15:0] header_word;
	} disk_req_t;

	// One result item: the register words of a segment, or a status.
	typedef struct {
		logic [1:0]  status;
		logic [15:0] seek_word;
		logic [15:0] disk_address_word;
		logic [17:0] bus_address;
		logic [15:0] word_count_word;
		logic [15:0] command_word;
		logic        last;
	} seg_result_t;

	logic clk;
	logic arst_n;

	dts_in_if  req_ch ();
	dts_out_if rsp_ch ();
	dts_cfg_if cfg_ch ();

	disk_transfer_segmenter_unit #(
		.DRIVES(NUM_DRIVES)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Results still owed by the block, oldest first.
	seg_result_t segments_due[$];

	// Mirror of the block's drive state and configuration.
	logic [9:0] drive_track [NUM_DRIVES];
	bit         drive_known [NUM_DRIVES];
	logic [3:0] present_bits;
	logic [3:0] large_bits;
	logic [1:0] ext_bits;

	int fail_count;
	int cycle_count;
	bit tx_steady;
	bit rx_steady;
	int rx_gap;
	int rx_hold_req;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Guard against a hung block.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Queue a single status result for an item.
	function automatic void expect_status(input logic [1:0] st);
		seg_result_t res;
		res = '{status: st, seek_word: '0, disk_address_word: '0, bus_address: '0,
			word_count_word: '0, command_word: '0, last: 1'b1};
		segments_due.push_back(res);
	endfunction

	// Work out the results of one accepted item and update the drive state.
	function automatic void plan_segments(input disk_req_t r);
		seg_result_t res;
		int          blocks_on_drive;
		logic [9:0]  track;
		logic [5:0]  sector;
		logic [17:0] addr;
		logic [8:0]  cur_cyl;
		logic [8:0]  dst_cyl;
		int          left;
		int          part;
		int          neg_words;
		logic [5:0]  func;

		if (r.action) begin
			drive_track[r.drive] = r.header_word[15:6];
			drive_known[r.drive] = 1'b1;
			expect_status(dts_pkg::ST_RECORD);
			return;
		end
		if (int'(r.drive) >= NUM_DRIVES || !present_bits[r.drive]) begin
			expect_status(dts_pkg::ST_BAD);
			return;
		end
		if (!drive_known[r.drive]) begin
			expect_status(dts_pkg::ST_UNKNOWN);
			return;
		end
		blocks_on_drive = large_bits[r.drive] ? int'(dts_pkg::LARGE_BLOCKS) :
			int'(dts_pkg::SMALL_BLOCKS);
		if (int'(r.block_number) >= blocks_on_drive) begin
			expect_status(dts_pkg::ST_BAD);
			return;
		end

		track  = 10'(int'(r.block_number) / 20);
		sector = 6'((int'(r.block_number) % 20) * 2);
		addr   = {ext_bits, r.memory_address};
		left   = int'(r.byte_count);
		func   = r.is_read ? dts_pkg::CMD_READ : dts_pkg::CMD_WRITE;

		// One result per track segment, at most eight.
		for (int k = 0; k < dts_pkg::MAX_SEGMENTS; k++) begin
			cur_cyl = drive_track[r.drive][9:1];
			dst_cyl = track[9:1];
			if (cur_cyl < dst_cyl)
				res.seek_word = {dst_cyl - cur_cyl, 7'd0} | 16'd5;
			else
				res.seek_word = {cur_cyl - dst_cyl, 7'd0} | 16'd1;
			res.seek_word = res.seek_word | {11'd0, track[0], 4'd0};
			drive_track[r.drive] = track;

			part = int'(dts_pkg::TRACK_BYTES) - int'(sector) * 256;
			if (left < part)
				part = left;
			neg_words = -(part / 2);
			left = left - part;

			res.status            = dts_pkg::ST_SEG;
			res.disk_address_word = {track, sector};
			res.bus_address       = addr;
			res.word_count_word   = neg_words[15:0];
			res.command_word      = {6'd0, r.drive, 8'd0} | {10'd0, func}
				| {10'd0, addr[17:16], 4'd0};
			res.last              = (left == 0 || k == dts_pkg::MAX_SEGMENTS - 1);
			segments_due.push_back(res);
			if (res.last)
				break;

			addr   = addr + 18'(part);
			sector = '0;
			track  = track + 10'd1;
		end
	endfunction

	// Report one field mismatch; only the first few are printed.
	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("mismatch in %s: expected %0h, got %0h", name, want, got);
		end
	endtask

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		seg_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (segments_due.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("unexpected result item, status %0d", rsp_ch.status);
			end else begin
				want = segments_due.pop_front();
				check_field("status", want.status, rsp_ch.status);
				check_field("seek_word", want.seek_word, rsp_ch.seek_word);
				check_field("disk_address_word", want.disk_address_word,
					rsp_ch.disk_address_word);
				check_field("bus_address", want.bus_address, rsp_ch.bus_address);
				check_field("word_count_word", want.word_count_word, rsp_ch.word_count_word);
				check_field("command_word", want.command_word, rsp_ch.command_word);
				check_field("last", want.last, rsp_ch.last);
			end
			rx_gap = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
		end
	end

	// Result receiver: random gaps per item, plus a long hold when one is requested.
	initial begin : rsp_sink
		int hold_left;
		hold_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req > 0) begin
				hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (rx_gap > 0) begin
				rsp_ch.ready <= 1'b0;
				rx_gap--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Offer one item after a random gap and wait until it is accepted.
	task automatic send_req(input disk_req_t r);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.action         <= r.action;
		req_ch.drive          <= r.drive;
		req_ch.is_read        <= r.is_read;
		req_ch.block_number   <= r.block_number;
		req_ch.byte_count     <= r.byte_count;
		req_ch.memory_address <= r.memory_address;
		req_ch.header_word    <= r.header_word;
		req_ch.valid          <= 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		plan_segments(r);
	endtask

	task automatic send_transfer(input logic [1:0] drive, input logic rd,
			input logic [15:0] block, input logic [15:0] bytes, input logic [15:0] maddr);
		disk_req_t r;
		r = '{action: 1'b0, drive: drive, is_read: rd, block_number: block,
			byte_count: bytes, memory_address: maddr, header_word: 16'h0000};
		send_req(r);
	endtask

	task automatic send_header(input logic [1:0] drive, input logic [15:0] hdr);
		disk_req_t r;
		r = '{action: 1'b1, drive: drive, is_read: 1'b0, block_number: 16'hffff,
			byte_count: 16'hffff, memory_address: 16'hffff, header_word: hdr};
		send_req(r);
	endtask

	// Drop valid, wait for every owed result, then let the block go idle.
	task automatic settle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (segments_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one configuration register.
	task automatic write_reg(input logic [dts_pkg::CFG_IDX_W-1:0] idx,
			input logic [dts_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			dts_pkg::REG_PRESENT: present_bits = val;
			dts_pkg::REG_LARGE: large_bits = val;
			dts_pkg::REG_EXT: ext_bits = val[1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_config(input logic [3:0] present, input logic [3:0] large_sel,
			input logic [1:0] ext);
		write_reg(dts_pkg::REG_PRESENT, present);
		write_reg(dts_pkg::REG_LARGE, large_sel);
		write_reg(dts_pkg::REG_EXT, {2'b00, ext});
	endtask

	// Draw a random item: mostly valid transfers, some header reports, some noise.
	function automatic disk_req_t make_random_req();
		disk_req_t r;
		int        roll;
		int        blocks_on_drive;
		int        blk;
		r.action         = 1'b0;
		r.drive          = 2'($urandom_range(0, 3));
		r.is_read        = 1'($urandom_range(0, 1));
		r.block_number   = 16'($urandom);
		r.byte_count     = 16'($urandom);
		r.memory_address = 16'($urandom);
		r.header_word    = 16'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 12) begin
			r.action = 1'b1;
		end else if (roll < 88) begin
			// Prefer a present drive so that the transfer gets past the checks.
			for (int t = 0; t < 8 && !present_bits[r.drive]; t++)
				r.drive = 2'($urandom_range(0, 3));
			blocks_on_drive = large_bits[r.drive] ? int'(dts_pkg::LARGE_BLOCKS) :
				int'(dts_pkg::SMALL_BLOCKS);
			blk = $urandom_range(0, blocks_on_drive - 1);
			if ($urandom_range(0, 3) == 0)
				blk = blk - blk % 20 + 19;
			r.block_number = 16'(blk);
			roll = $urandom_range(0, 9);
			if (roll < 6)
				r.byte_count = 16'($urandom_range(0, 12000));
			else if (roll < 9)
				r.byte_count = 16'($urandom_range(0, 40000));
		end else begin
			r.action = 1'($urandom_range(0, 1));
		end
		return r;
	endfunction

	// Error paths, unknown position and header reports.
	task automatic test_status_cases();
		set_config(4'b1110, 4'b0000, 2'd0);
		send_transfer(2'd0, 1'b1, 16'd0, 16'd512, 16'h0000);
		send_transfer(2'd1, 1'b1, 16'd0, 16'd512, 16'h0000);
		send_header(2'd0, 16'hffff);
		send_header(2'd1, 16'h0000);
		send_header(2'd2, 16'h0040);
		send_header(2'd3, 16'h1234);
		send_transfer(2'd0, 1'b0, 16'd0, 16'd512, 16'h0000);
		send_transfer(2'd1, 1'b1, 16'd10240, 16'd512, 16'h0000);
		send_transfer(2'd2, 1'b0, 16'hffff, 16'hffff, 16'hffff);
		settle();
	endtask

	// Segmenting: zero and odd counts, the longest request, track and address wrap.
	task automatic test_segment_cases();
		set_config(4'b1111, 4'b1010, 2'd0);
		send_header(2'd0, 16'hffc0);
		send_transfer(2'd1, 1'b1, 16'd0, 16'd0, 16'h0000);
		send_transfer(2'd1, 1'b0, 16'd19, 16'hffff, 16'hffff);
		send_transfer(2'd2, 1'b1, 16'd10239, 16'd513, 16'h1234);
		send_transfer(2'd3, 1'b1, 16'd20479, 16'd30000, 16'h0200);
		send_transfer(2'd3, 1'b0, 16'd20480, 16'd100, 16'h0000);
		send_transfer(2'd1, 1'b0, 16'd20479, 16'd1, 16'h8001);
		send_transfer(2'd0, 1'b1, 16'd100, 16'd4096, 16'h1000);
		settle();
		set_config(4'b1111, 4'b1111, 2'd3);
		send_transfer(2'd2, 1'b0, 16'd0, 16'hffff, 16'hf000);
		send_transfer(2'd0, 1'b1, 16'd5000, 16'd12345, 16'hffff);
		send_transfer(2'd3, 1'b1, 16'd40, 16'd20480, 16'h0000);
		settle();
	endtask

	// The receiver holds off while the sender keeps offering, so the input stalls.
	task automatic test_backpressure();
		tx_steady = 1'b1;
		@(posedge clk);
		rx_hold_req = LONG_HOLD;
		for (int i = 0; i < 12; i++)
			send_req(make_random_req());
		tx_steady = 1'b0;
		settle();
	endtask

	// Random traffic over several configurations, the extremes among them.
	task automatic test_random_traffic();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: set_config(4'b1111, 4'b1111, 2'd3);
				1: set_config(4'b1111, 4'b0000, 2'd0);
				2: set_config(4'b0000, 4'b0101, 2'd1);
				default: set_config(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					2'($urandom_range(0, 3)));
			endcase
			for (int i = 0; i < 32; i++) begin
				if ($urandom_range(0, 15) == 0)
					tx_steady = !tx_steady;
				if ($urandom_range(0, 15) == 0)
					rx_steady = !rx_steady;
				send_req(make_random_req());
			end
			tx_steady = 1'b0;
			rx_steady = 1'b0;
			settle();
		end
	endtask

	// Reset, run the tests in turn, and report.
	initial begin
		req_ch.valid          = 1'b0;
		req_ch.action         = 1'b0;
		req_ch.drive          = '0;
		req_ch.is_read        = 1'b0;
		req_ch.block_number   = '0;
		req_ch.byte_count     = '0;
		req_ch.memory_address = '0;
		req_ch.header_word    = '0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.index          = dts_pkg::REG_PRESENT;
		cfg_ch.data           = '0;
		arst_n                = 1'b0;
		fail_count            = 0;
		cycle_count           = 0;
		tx_steady             = 1'b0;
		rx_steady             = 1'b0;
		rx_gap                = 0;
		rx_hold_req           = 0;
		present_bits          = '0;
		large_bits            = '0;
		ext_bits              = '0;
		for (int d = 0; d < NUM_DRIVES; d++) begin
			drive_track[d] = '0;
			drive_known[d] = 1'b0;
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		test_status_cases();
		test_segment_cases();
		test_backpressure();
		test_random_traffic();
		settle();

		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
